// ===== design/ioef_pkg.sv =====
// ----------------------------------------------------------------------------
// ioef_pkg
// Shared types, constants and the cosine table function of the IR
// observation-error inflation factor block.
// ----------------------------------------------------------------------------
package ioef_pkg;

  localparam int unsigned COS_TABLE_BITS = 10;

  localparam int unsigned WN_W    = 19;
  localparam int unsigned WATER_W = 16;
  localparam int unsigned ZEN_W   = 15;
  localparam int unsigned TAU_W   = 16;
  localparam int unsigned MAXZ_W  = 14;
  localparam int unsigned FAC_W   = 24;
  localparam int unsigned CFG_W   = 19;
  localparam int unsigned COS_W   = 17;
  localparam int unsigned PT_W    = WN_W + TAU_W;
  localparam int unsigned P_W     = PT_W + COS_W;
  localparam int unsigned E_W     = 47;
  localparam int unsigned V_W     = 48;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned SQRT_STEPS = 24;

  localparam logic [WN_W-1:0]   BAND_LOW_RST  = WN_W'(200000);
  localparam logic [WN_W-1:0]   BAND_HIGH_RST = WN_W'(240000);
  localparam logic [MAXZ_W-1:0] MAX_ZEN_RST   = MAXZ_W'(8900);

  localparam logic [ZEN_W-1:0] ZEN_RIGHT = ZEN_W'(9000);
  localparam logic [P_W-1:0]   DEN_SCALE = P_W'(64'd40000 << 31);
  localparam logic [E_W-1:0]   SAT_E     = E_W'(64'd40000 << 15);
  localparam logic [FAC_W-1:0] FACTOR_ONE = FAC_W'(65536);
  localparam logic [FAC_W-1:0] FACTOR_MAX = '1;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint          ONE_Q30     = 64'sd1073741824;

  typedef enum logic [1:0] {
    REG_BAND_LOW  = 2'd0,
    REG_BAND_HIGH = 2'd1,
    REG_MAX_ZEN   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic valid;
    logic inflate;
    logic sat;
  } ctl_t;

  function automatic logic [COS_W-1:0] cos_q16(int unsigned idx, int unsigned bits);
    longint unsigned theta;
    longint unsigned u;
    longint unsigned mag;
    longint unsigned c;
    longint          h;
    longint          t;
    int              k;
    theta = (longint'(idx) * HALF_PI_Q30) >> bits;
    u = (theta * theta) >> 30;
    h = ONE_Q30;
    for (k = 0; k < 6; k++) begin
      mag = (h < 0) ? longint'(-h) : longint'(h);
      t = longint'((u * mag) >> 30);
      if (h < 0) t = -t;
      case (k)
        0: h = ONE_Q30 - t / 132;
        1: h = ONE_Q30 - t / 90;
        2: h = ONE_Q30 - t / 56;
        3: h = ONE_Q30 - t / 30;
        4: h = ONE_Q30 - t / 12;
        default: h = ONE_Q30 - t / 2;
      endcase
    end
    if (h <= 0) return '0;
    c = (longint'(h) + 64'd8192) >> 14;
    if (c > 64'd65536) c = 64'd65536;
    return COS_W'(c);
  endfunction

endpackage

// ===== design/ioef_if.sv =====
// ----------------------------------------------------------------------------
// ioef_if
// Request channels of the inflation factor block: input, result, config.
// ----------------------------------------------------------------------------
interface ioef_in_if;
  logic                             valid;
  logic                             ready;
  logic [ioef_pkg::WN_W-1:0]        wavenumber;
  logic [ioef_pkg::WATER_W-1:0]     water_fraction;
  logic [ioef_pkg::ZEN_W-1:0]       solar_zenith;
  logic [ioef_pkg::TAU_W-1:0]       surface_transmittance;
  modport source (output valid, wavenumber, water_fraction, solar_zenith,
                  surface_transmittance, input ready);
  modport sink   (input valid, wavenumber, water_fraction, solar_zenith,
                  surface_transmittance, output ready);
endinterface

interface ioef_out_if;
  logic                         valid;
  logic                         ready;
  logic [ioef_pkg::FAC_W-1:0]   error_factor;
  logic                         saturated;
  modport source (output valid, error_factor, saturated, input ready);
  modport sink   (input valid, error_factor, saturated, output ready);
endinterface

interface ioef_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   index;
  logic [ioef_pkg::CFG_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/ioef_front.sv =====
// ----------------------------------------------------------------------------
// ioef_front
// Band qualification, cosine lookup, product and denominator stages.
// ----------------------------------------------------------------------------
module ioef_front #(
  parameter int unsigned CosTableBits = ioef_pkg::COS_TABLE_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            adv_i,
  input  logic                            valid_i,
  input  logic [ioef_pkg::WN_W-1:0]       wavenumber_i,
  input  logic [ioef_pkg::WATER_W-1:0]    water_fraction_i,
  input  logic [ioef_pkg::ZEN_W-1:0]      solar_zenith_i,
  input  logic [ioef_pkg::TAU_W-1:0]      surface_transmittance_i,
  input  logic [ioef_pkg::WN_W-1:0]       band_low_i,
  input  logic [ioef_pkg::WN_W-1:0]       band_high_i,
  input  logic [ioef_pkg::MAXZ_W-1:0]     max_zen_i,
  output ioef_pkg::ctl_t                  ctl_o,
  output logic [ioef_pkg::E_W-1:0]        e_o
);

  localparam int unsigned NW = CosTableBits + 16;
  localparam int unsigned MW = NW + 1;
  localparam int unsigned IW = CosTableBits + 1;
  localparam int unsigned TD = (1 << CosTableBits) + 1;
  localparam int unsigned SH = NW + 14;
  localparam longint unsigned RECIP = (64'd1 << SH) / 9000;
  localparam logic [MW-1:0] RECIP_M = MW'(RECIP);
  localparam logic [NW-1:0] ROUND_N = NW'(4500);
  localparam logic [NW-1:0] STEP_N  = NW'(9000);

  logic [ioef_pkg::COS_W-1:0] cos_tbl [TD];
  for (genvar g = 0; g < TD; g++) begin : g_tbl
    assign cos_tbl[g] = ioef_pkg::cos_q16(g, CosTableBits);
  end

  logic [5:0] v_q;
  logic [5:0] inf_q;
  logic [2:0] zhi_q;

  logic [ioef_pkg::WN_W-1:0]  d1_q;
  logic [ioef_pkg::TAU_W-1:0] tau1_q;
  logic [NW-1:0]              n1_q, n2_q;
  logic [IW-1:0]              q2_q, idx3_q;
  logic [ioef_pkg::PT_W-1:0]  pt2_q, pt3_q, pt4_q;
  logic [ioef_pkg::COS_W-1:0] cos4_q;
  logic [ioef_pkg::P_W-1:0]   p5_q;
  logic                       sat6_q;
  logic [ioef_pkg::E_W-1:0]   e6_q;

  logic                       zhi_d, inf_d;
  logic [NW-1:0]              n1_d;
  logic [NW+MW-1:0]           prod;
  logic [NW-1:0]              r3;
  logic [ioef_pkg::P_W-1:0]   e_full;

  assign zhi_d = solar_zenith_i >= ioef_pkg::ZEN_RIGHT;
  assign inf_d = (wavenumber_i > band_low_i) && (wavenumber_i <= band_high_i) &&
                 (water_fraction_i != '0) &&
                 (solar_zenith_i <= ioef_pkg::ZEN_W'(max_zen_i));
  assign n1_d  = zhi_d ? '0 : (NW'(solar_zenith_i) << CosTableBits) + ROUND_N;
  assign prod  = (NW+MW)'(n1_q) * (NW+MW)'(RECIP_M);
  assign r3    = n2_q - NW'(q2_q) * STEP_N;
  assign e_full = ioef_pkg::DEN_SCALE - p5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      inf_q  <= {inf_q[4:0], inf_d};
      zhi_q  <= {zhi_q[1:0], zhi_d};
      d1_q   <= wavenumber_i - band_low_i;
      tau1_q <= surface_transmittance_i;
      n1_q   <= n1_d;
      n2_q   <= n1_q;
      q2_q   <= IW'(prod >> SH);
      pt2_q  <= ioef_pkg::PT_W'(d1_q) * ioef_pkg::PT_W'(tau1_q);
      pt3_q  <= pt2_q;
      pt4_q  <= pt3_q;
      idx3_q <= q2_q + IW'(r3 >= STEP_N);
      cos4_q <= zhi_q[2] ? '0 : cos_tbl[idx3_q];
      p5_q   <= ioef_pkg::P_W'(pt4_q) * ioef_pkg::P_W'(cos4_q);
      sat6_q <= (p5_q >= ioef_pkg::DEN_SCALE) ||
                (e_full[ioef_pkg::E_W-1:0] <= ioef_pkg::SAT_E);
      e6_q   <= e_full[ioef_pkg::E_W-1:0];
    end
  end

  assign ctl_o.valid   = v_q[5];
  assign ctl_o.inflate = inf_q[5];
  assign ctl_o.sat     = sat6_q;
  assign e_o           = e6_q;

endmodule

// ===== design/ioef_div.sv =====
// ----------------------------------------------------------------------------
// ioef_div
// Restoring divider, one quotient bit per stage: V = D * 2^32 / E.
// ----------------------------------------------------------------------------
module ioef_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  ioef_pkg::ctl_t              ctl_i,
  input  logic [ioef_pkg::E_W-1:0]    e_i,
  output ioef_pkg::ctl_t              ctl_o,
  output logic [ioef_pkg::V_W-1:0]    v_o
);

  localparam int unsigned N = ioef_pkg::DIV_STEPS;
  localparam int unsigned VW = ioef_pkg::V_W;

  ioef_pkg::ctl_t            ctl_q [N];
  logic [ioef_pkg::E_W-1:0]  e_q   [N];
  logic [VW-1:0]             r_q   [N];
  logic [VW-1:0]             quo_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    ioef_pkg::ctl_t            ctl_s;
    logic [ioef_pkg::E_W-1:0]  e_s;
    logic [VW-1:0]             r_s, q_s, r_sh, r_sub;
    logic                      ge;
    if (g == 0) begin : g_first
      assign ctl_s = ctl_i;
      assign e_s   = e_i;
      assign r_s   = VW'(ioef_pkg::SAT_E);
      assign q_s   = '0;
    end else begin : g_next
      assign ctl_s = ctl_q[g-1];
      assign e_s   = e_q[g-1];
      assign r_s   = r_q[g-1];
      assign q_s   = quo_q[g-1];
    end
    assign r_sh  = {r_s[VW-2:0], 1'b0};
    assign ge    = r_sh >= VW'(e_s);
    assign r_sub = r_sh - VW'(e_s);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[g] <= '0;
      end else if (adv_i) begin
        ctl_q[g] <= ctl_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        e_q[g]   <= e_s;
        r_q[g]   <= ge ? r_sub : r_sh;
        quo_q[g] <= {q_s[VW-2:0], ge};
      end
    end
  end

  assign ctl_o = ctl_q[N-1];
  assign v_o   = quo_q[N-1];

endmodule

// ===== design/ioef_sqrt.sv =====
// ----------------------------------------------------------------------------
// ioef_sqrt
// Digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ioef_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  ioef_pkg::ctl_t              ctl_i,
  input  logic [ioef_pkg::V_W-1:0]    v_i,
  output ioef_pkg::ctl_t              ctl_o,
  output logic [ioef_pkg::FAC_W-1:0]  root_o
);

  localparam int unsigned N  = ioef_pkg::SQRT_STEPS;
  localparam int unsigned VW = ioef_pkg::V_W;
  localparam int unsigned RW = VW + 1;

  ioef_pkg::ctl_t  ctl_q  [N];
  logic [VW-1:0]   rem_q  [N];
  logic [RW-1:0]   root_q [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (VW - 2 - 2 * g);
    ioef_pkg::ctl_t  ctl_s;
    logic [VW-1:0]   rem_s;
    logic [RW-1:0]   root_s, trial;
    logic            ge;
    if (g == 0) begin : g_first
      assign ctl_s  = ctl_i;
      assign rem_s  = v_i;
      assign root_s = '0;
    end else begin : g_next
      assign ctl_s  = ctl_q[g-1];
      assign rem_s  = rem_q[g-1];
      assign root_s = root_q[g-1];
    end
    assign trial = root_s + BIT;
    assign ge    = RW'(rem_s) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[g] <= '0;
      end else if (adv_i) begin
        ctl_q[g] <= ctl_s;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[g]  <= ge ? rem_s - trial[VW-1:0] : rem_s;
        root_q[g] <= ge ? (root_s >> 1) + BIT : root_s >> 1;
      end
    end
  end

  assign ctl_o  = ctl_q[N-1];
  assign root_o = root_q[N-1][ioef_pkg::FAC_W-1:0];

endmodule

// ===== design/ir_obs_error_inflation_factor_top.sv =====
// ----------------------------------------------------------------------------
// ir_obs_error_inflation_factor_top
// IR observation-error inflation factor, Q8.16 result with saturation flag.
// ----------------------------------------------------------------------------
// The block takes one observation request per cycle, unless the pipeline is
// holding, and returns one result per request in order through 78 register
// stages: 6 front stages (band check, cosine index, table lookup, products,
// denominator), 48 divider stages (one quotient bit each) and 24 square-root
// stages (one root bit each), the last of which is the output register. The
// whole pipeline holds while a result waits on the output; configuration is
// written through the config channel, which is always ready.
module ir_obs_error_inflation_factor_top #(
  parameter int unsigned CosTableBits = ioef_pkg::COS_TABLE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ioef_in_if.sink     in_i,
  ioef_out_if.source  out_o,
  ioef_cfg_if.sink    cfg_i
);

  logic [ioef_pkg::WN_W-1:0]   band_low_q, band_high_q;
  logic [ioef_pkg::MAXZ_W-1:0] max_zen_q;

  ioef_pkg::ctl_t              fr_ctl, dv_ctl, sq_ctl;
  logic [ioef_pkg::E_W-1:0]    fr_e;
  logic [ioef_pkg::V_W-1:0]    dv_v;
  logic [ioef_pkg::FAC_W-1:0]  sq_root;
  logic                        adv;

  assign adv         = !sq_ctl.valid || out_o.ready;
  assign in_i.ready  = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_low_q  <= ioef_pkg::BAND_LOW_RST;
      band_high_q <= ioef_pkg::BAND_HIGH_RST;
      max_zen_q   <= ioef_pkg::MAX_ZEN_RST;
    end else if (cfg_i.valid) begin
      unique case (ioef_pkg::reg_idx_e'(cfg_i.index))
        ioef_pkg::REG_BAND_LOW:  band_low_q  <= cfg_i.data;
        ioef_pkg::REG_BAND_HIGH: band_high_q <= cfg_i.data;
        ioef_pkg::REG_MAX_ZEN:   max_zen_q   <= cfg_i.data[ioef_pkg::MAXZ_W-1:0];
        default: ;
      endcase
    end
  end

  ioef_front #(.CosTableBits(CosTableBits)) u_front (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .adv_i                  (adv),
    .valid_i                (in_i.valid),
    .wavenumber_i           (in_i.wavenumber),
    .water_fraction_i       (in_i.water_fraction),
    .solar_zenith_i         (in_i.solar_zenith),
    .surface_transmittance_i(in_i.surface_transmittance),
    .band_low_i             (band_low_q),
    .band_high_i            (band_high_q),
    .max_zen_i              (max_zen_q),
    .ctl_o                  (fr_ctl),
    .e_o                    (fr_e)
  );

  ioef_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (fr_ctl),
    .e_i    (fr_e),
    .ctl_o  (dv_ctl),
    .v_o    (dv_v)
  );

  ioef_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .ctl_i  (dv_ctl),
    .v_i    (dv_v),
    .ctl_o  (sq_ctl),
    .root_o (sq_root)
  );

  assign out_o.valid        = sq_ctl.valid;
  assign out_o.error_factor = !sq_ctl.inflate ? ioef_pkg::FACTOR_ONE :
                              sq_ctl.sat      ? ioef_pkg::FACTOR_MAX : sq_root;
  assign out_o.saturated    = sq_ctl.inflate && sq_ctl.sat;

endmodule

// ===== dv/ioef_checker.sv =====
// ----------------------------------------------------------------------------
// ioef_checker
// Watches the request, result and config channels of the inflation factor
// block, predicts each factor in order and compares it with the result.
// ----------------------------------------------------------------------------
module ioef_checker (
  input  logic     clk_i,
  input  logic     rst_ni,
  ioef_in_if.sink  in_i,
  ioef_out_if.sink out_o,
  ioef_cfg_if.sink cfg_i,
  output int       fail_count_o,
  output int       pending_o,
  output logic     accept_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ioef_pkg::FAC_W-1:0] factor;
    logic                       sat;
  } factor_t;

  logic [ioef_pkg::WN_W-1:0]   band_low;
  logic [ioef_pkg::WN_W-1:0]   band_high;
  logic [ioef_pkg::MAXZ_W-1:0] max_zen;
  factor_t                     expected_q[$];
  int                          fails;

  function automatic longint unsigned cosine_q16(longint unsigned zen);
    longint unsigned idx, theta, u, mag;
    longint          h, t;
    longint          divs[6];
    divs = '{132, 90, 56, 30, 12, 2};
    if (zen >= 9000) return 0;
    idx = ((zen << ioef_pkg::COS_TABLE_BITS) + 4500) / 9000;
    theta = (idx * 64'd1686629713) >> ioef_pkg::COS_TABLE_BITS;
    u = (theta * theta) >> 30;
    h = 64'sd1073741824;
    for (int k = 0; k < 6; k++) begin
      mag = (h < 0) ? longint'(-h) : longint'(h);
      t = longint'((u * mag) >> 30);
      if (h < 0) t = -t;
      h = 64'sd1073741824 - t / divs[k];
    end
    if (h <= 0) return 0;
    mag = (longint'(h) + 8192) >> 14;
    return (mag > 65536) ? 65536 : mag;
  endfunction

  function automatic longint unsigned root48(longint unsigned v);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 48;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic factor_t inflation_factor(longint unsigned wn, longint unsigned water,
                                               longint unsigned zen, longint unsigned tau);
    longint unsigned scale, p, e, q, rem, v;
    factor_t r;
    scale = 64'd40000 << 31;
    r.factor = ioef_pkg::FACTOR_ONE;
    r.sat = 1'b0;
    if (wn > band_low && wn <= band_high && water != 0 && zen <= max_zen) begin
      p = (wn - band_low) * tau * cosine_q16(zen);
      if (p >= scale) begin
        r.factor = ioef_pkg::FACTOR_MAX;
        r.sat = 1'b1;
      end else begin
        e = scale - p;
        q = scale / e;
        rem = scale % e;
        if (q >= 65536) begin
          r.factor = ioef_pkg::FACTOR_MAX;
          r.sat = 1'b1;
        end else begin
          v = q;
          for (int i = 0; i < 32; i++) begin
            rem <<= 1;
            v <<= 1;
            if (rem >= e) begin
              rem -= e;
              v |= 1;
            end
          end
          v = root48(v);
          if (v > 64'hFFFFFF) begin
            r.factor = ioef_pkg::FACTOR_MAX;
            r.sat = 1'b1;
          end else begin
            r.factor = ioef_pkg::FAC_W'(v);
          end
        end
      end
    end
    return r;
  endfunction

  assign fail_count_o = fails;
  assign pending_o = expected_q.size();
  assign accept_o = (in_i.valid && in_i.ready) || (out_o.valid && out_o.ready);

  always @(posedge clk_i or negedge rst_ni) begin
    factor_t want;
    if (!rst_ni) begin
      band_low <= ioef_pkg::BAND_LOW_RST;
      band_high <= ioef_pkg::BAND_HIGH_RST;
      max_zen <= ioef_pkg::MAX_ZEN_RST;
      fails = 0;
      expected_q.delete();
    end else begin
      if (in_i.valid && in_i.ready)
        expected_q.insert(expected_q.size(),
                          inflation_factor(in_i.wavenumber, in_i.water_fraction,
                                           in_i.solar_zenith, in_i.surface_transmittance));
      if (out_o.valid && out_o.ready) begin
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result factor=%0d", out_o.error_factor);
        end else begin
          want = expected_q.pop_front();
          if (want.factor !== out_o.error_factor || want.sat !== out_o.saturated) begin
            fails++;
            if (fails <= 10)
              $display("mismatch: expected factor=%0d sat=%0d, got factor=%0d sat=%0d",
                       want.factor, want.sat, out_o.error_factor, out_o.saturated);
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          ioef_pkg::REG_BAND_LOW:  band_low <= cfg_i.data;
          ioef_pkg::REG_BAND_HIGH: band_high <= cfg_i.data;
          ioef_pkg::REG_MAX_ZEN:   max_zen <= cfg_i.data[ioef_pkg::MAXZ_W-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives observation requests and register writes into the inflation factor
// block under several idle patterns and settings; the checker scores results.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 78;
  localparam int STALL_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle = 0;
  int   recv_idle = 0;
  logic hold_off = 1'b0;
  int   fail_count, pending;
  logic accept;
  int   quiet = 0;

  ioef_in_if  in_ch();
  ioef_out_if out_ch();
  ioef_cfg_if cfg_ch();

  always #2 clk_i = ~clk_i;

  ir_obs_error_inflation_factor_top i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .cfg_i(cfg_ch.sink)
  );

  ioef_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.sink),
    .cfg_i(cfg_ch.sink), .fail_count_o(fail_count), .pending_o(pending), .accept_o(accept)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.wavenumber = '0;
    in_ch.water_fraction = '0;
    in_ch.solar_zenith = '0;
    in_ch.surface_transmittance = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = ioef_pkg::REG_BAND_LOW;
    cfg_ch.data = '0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (accept) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send(input logic [ioef_pkg::WN_W-1:0] wn,
                      input logic [ioef_pkg::WATER_W-1:0] water,
                      input logic [ioef_pkg::ZEN_W-1:0] zen,
                      input logic [ioef_pkg::TAU_W-1:0] tau);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.wavenumber <= wn;
    in_ch.water_fraction <= water;
    in_ch.solar_zenith <= zen;
    in_ch.surface_transmittance <= tau;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic write_reg(input ioef_pkg::reg_idx_e idx,
                           input logic [ioef_pkg::CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [ioef_pkg::CFG_W-1:0] lo,
                           input logic [ioef_pkg::CFG_W-1:0] hi,
                           input logic [ioef_pkg::CFG_W-1:0] mz);
    drain();
    write_reg(ioef_pkg::REG_BAND_LOW, lo);
    write_reg(ioef_pkg::REG_BAND_HIGH, hi);
    write_reg(ioef_pkg::REG_MAX_ZEN, mz);
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly in-band, daytime, nonzero water; the rest is full-range noise.
  task automatic random_obs(input logic [ioef_pkg::CFG_W-1:0] lo,
                            input logic [ioef_pkg::CFG_W-1:0] hi);
    logic [ioef_pkg::WN_W-1:0] wn;
    logic [ioef_pkg::ZEN_W-1:0] zen;
    if ($urandom_range(99) < 75) begin
      wn = (hi > lo) ? ioef_pkg::WN_W'($urandom_range(hi, lo + 1)) :
                       ioef_pkg::WN_W'($urandom);
      zen = ($urandom_range(3) == 0) ? ioef_pkg::ZEN_W'($urandom_range(9100)) :
                                       ioef_pkg::ZEN_W'($urandom_range(9000));
      send(wn, ioef_pkg::WATER_W'($urandom_range(65535, 1)), zen,
           ioef_pkg::TAU_W'($urandom_range(32768)));
    end else begin
      send(ioef_pkg::WN_W'($urandom), ioef_pkg::WATER_W'($urandom),
           ioef_pkg::ZEN_W'($urandom), ioef_pkg::TAU_W'($urandom));
    end
  endtask

  initial begin
    logic [ioef_pkg::CFG_W-1:0] lo_set[6];
    logic [ioef_pkg::CFG_W-1:0] hi_set[6];
    logic [ioef_pkg::CFG_W-1:0] mz_set[6];
    int phase;
    lo_set = '{200000, 0, 100000, 300000, 0, 400000};
    hi_set = '{240000, 400000, 300000, 200000, 524287, 524287};
    mz_set = '{8900, 9000, 4500, 8900, 16383, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(200000, 100, 0, 32768);
    send(200001, 100, 0, 32768);
    send(240000, 65535, 0, 32768);
    send(240001, 1, 0, 32768);
    send(220000, 0, 0, 32768);
    send(240000, 1, 8900, 32768);
    send(240000, 1, 8901, 32768);
    send(240000, 1, 9000, 32768);
    send(240000, 1, 32767, 65535);
    send(240000, 1, 0, 0);
    send(524287, 65535, 0, 65535);
    send(0, 1, 0, 32768);
    send(230000, 12345, 4500, 16384);
    configure(0, 524287, 16383);
    send(524287, 65535, 0, 65535);
    send(400000, 1, 0, 32768);
    send(300000, 1, 0, 32768);
    send(200000, 1, 100, 32768);
    send(524287, 65535, 16383, 65535);
    configure(300000, 200000, 8900);
    send(250000, 1, 0, 32768);

    for (phase = 0; phase < 6; phase++) begin
      configure(lo_set[phase], hi_set[phase], mz_set[phase]);
      send_idle = (phase < 2) ? 36 : (phase < 4) ? 83 : 0;
      recv_idle = (phase < 2) ? 83 : (phase < 4) ? 36 : 0;
      if (phase == 4) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (240) random_obs(lo_set[phase], hi_set[phase]);
    end
    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== files.f =====
design/ioef_pkg.sv
design/ioef_if.sv
design/ioef_front.sv
design/ioef_div.sv
design/ioef_sqrt.sv
design/ir_obs_error_inflation_factor_top.sv
dv/ioef_checker.sv
dv/testbench.sv
